>>> rtl/gha_pkg.sv
// Package for the generational handle allocator.
// Holds widths, command and status codes, the slot entry layout and the control states.
// No dependencies.
package gha_pkg;

  localparam int SLOT_BITS    = 10;
  localparam int VERSION_BITS = 16;
  localparam int HANDLE_BITS  = SLOT_BITS + VERSION_BITS;
  localparam int SLOT_DEPTH   = 1 << SLOT_BITS;
  localparam int ENTRY_BITS   = HANDLE_BITS + 1;

  localparam logic [SLOT_BITS:0]      SLOT_COUNT  = {1'b1, {SLOT_BITS{1'b0}}};
  localparam logic [HANDLE_BITS-1:0]  NULL_HANDLE = {HANDLE_BITS{1'b1}};
  localparam logic [VERSION_BITS-1:0] VER_MAX     = {VERSION_BITS{1'b1}};

  typedef enum logic [1:0] {
    CMD_ALLOC        = 2'd0,
    CMD_RELEASE      = 2'd1,
    CMD_QUERY_HANDLE = 2'd2,
    CMD_QUERY_SLOT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_DEAD_RELEASE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic                   live;
    logic [HANDLE_BITS-1:0] value;
  } entry_t;

endpackage

>>> rtl/gha_in_if.sv
// Request channel of the handle allocator: valid/ready plus request fields.
// Depends on gha_pkg.
interface gha_in_if import gha_pkg::*; ();
  logic                   valid;
  logic                   ready;
  cmd_t                   command;
  logic [HANDLE_BITS-1:0] handle;
  logic [SLOT_BITS-1:0]   slot_index;

  modport source (output valid, output command, output handle, output slot_index,
                  input ready);
  modport sink   (input valid, input command, input handle, input slot_index,
                  output ready);
endinterface

>>> rtl/gha_out_if.sv
// Result channel of the handle allocator: valid/ready plus result fields.
// Depends on gha_pkg.
interface gha_out_if import gha_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [HANDLE_BITS-1:0] new_handle;
  logic                   alive;
  status_t                status;

  modport source (output valid, output new_handle, output alive, output status,
                  input ready);
  modport sink   (input valid, input new_handle, input alive, input status,
                  output ready);
endinterface

>>> rtl/gha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/generational_handle_allocator.sv
// Generational handle allocator top level: slot table RAM, free list registers, result register.
// Depends on gha_pkg, gha_in_if, gha_out_if and gha_ram.
//
// Each request first reads the slot entry from the table RAM, then modifies it, writes it back
// and loads the result register. Requests are handled one at a time;
// a new request is taken while the previous result still waits on the output. The table
// needs no clearing pass after reset: only slots below the created count are ever consulted,
// and each is written when it is created.
module generational_handle_allocator import gha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gha_in_if.sink     in_ch,
  gha_out_if.source  out_ch
);

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [SLOT_BITS-1:0]   addr_r, addr_nxt;
  logic [SLOT_BITS:0]     slots_created_r, slots_created_nxt;
  logic [SLOT_BITS:0]     free_count_r, free_count_nxt;
  logic [HANDLE_BITS-1:0] free_head_r, free_head_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [HANDLE_BITS-1:0] out_handle_r, out_handle_nxt;
  logic                   out_alive_r, out_alive_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                   in_beat;
  logic                   exec_go;
  logic                   we;
  entry_t                 wentry;
  entry_t                 rentry;
  logic [ENTRY_BITS-1:0]  rdata;
  logic [SLOT_BITS-1:0]   raddr;
  logic                   slot_made;
  logic                   handle_live;
  logic [VERSION_BITS-1:0] ver_inc;
  logic [HANDLE_BITS-1:0] bumped;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign exec_go     = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_handle = out_handle_r;
  assign out_ch.alive      = out_alive_r;
  assign out_ch.status     = out_status_r;

  always_comb begin
    unique case (in_ch.command)
      CMD_ALLOC: begin
        addr_nxt = (free_count_r != '0) ? free_head_r[HANDLE_BITS-1:VERSION_BITS]
                                        : slots_created_r[SLOT_BITS-1:0];
      end
      CMD_RELEASE, CMD_QUERY_HANDLE: begin
        addr_nxt = in_ch.handle[HANDLE_BITS-1:VERSION_BITS];
      end
      CMD_QUERY_SLOT: begin
        addr_nxt = in_ch.slot_index;
      end
      default: begin
        addr_nxt = in_ch.slot_index;
      end
    endcase
  end

  assign raddr = (state_r == S_IDLE) ? addr_nxt : addr_r;

  gha_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (SLOT_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (addr_r),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rentry      = entry_t'(rdata);
  assign slot_made   = {1'b0, addr_r} < slots_created_r;
  assign handle_live = slot_made && rentry.live && (rentry.value == handle_r);
  assign ver_inc     = handle_r[VERSION_BITS-1:0] + 1'b1;
  assign bumped      = {handle_r[HANDLE_BITS-1:VERSION_BITS], ver_inc};

  always_comb begin
    we                = 1'b0;
    wentry            = '{live: 1'b0, value: bumped};
    slots_created_nxt = slots_created_r;
    free_count_nxt    = free_count_r;
    free_head_nxt     = free_head_r;
    out_handle_nxt    = NULL_HANDLE;
    out_alive_nxt     = 1'b0;
    out_status_nxt    = ST_OK;
    unique case (cmd_r)
      CMD_ALLOC: begin
        if (free_count_r != '0) begin
          out_handle_nxt = free_head_r;
          free_head_nxt  = rentry.value;
          free_count_nxt = free_count_r - 1'b1;
          wentry         = '{live: 1'b1, value: free_head_r};
          we             = exec_go;
        end else if (slots_created_r < SLOT_COUNT) begin
          out_handle_nxt    = {addr_r, {VERSION_BITS{1'b0}}};
          slots_created_nxt = slots_created_r + 1'b1;
          wentry            = '{live: 1'b1, value: {addr_r, {VERSION_BITS{1'b0}}}};
          we                = exec_go;
        end else begin
          out_status_nxt = ST_FULL;
        end
      end
      CMD_RELEASE: begin
        if (!handle_live) begin
          out_status_nxt = ST_DEAD_RELEASE;
        end else if (ver_inc == VER_MAX) begin
          wentry = '{live: 1'b0, value: bumped};
          we     = exec_go;
        end else begin
          wentry         = '{live: 1'b0, value: free_head_r};
          free_head_nxt  = bumped;
          free_count_nxt = free_count_r + 1'b1;
          we             = exec_go;
        end
      end
      CMD_QUERY_HANDLE: begin
        out_alive_nxt = handle_live;
      end
      CMD_QUERY_SLOT: begin
        out_alive_nxt = slot_made && rentry.live;
      end
      default: begin
        out_alive_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      slots_created_r <= '0;
      free_count_r    <= '0;
      free_head_r     <= NULL_HANDLE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        slots_created_r <= slots_created_nxt;
        free_count_r    <= free_count_nxt;
        free_head_r     <= free_head_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_r    <= in_ch.command;
      handle_r <= in_ch.handle;
      addr_r   <= addr_nxt;
    end
    if (exec_go) begin
      out_handle_r <= out_handle_nxt;
      out_alive_r  <= out_alive_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  a_free_within_created: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= slots_created_r)
    else $error("free list longer than created slots");

  a_created_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_created_r <= SLOT_COUNT)
    else $error("created slot count overflow");

  a_beat_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == S_EXEC))
    else $error("accepted beat not executed");

  a_exec_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("executed request produced no result");

  a_full_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_handle_r == NULL_HANDLE))
    else $error("full status with a non-null handle");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for generational_handle_allocator: a driver and a monitor on the
// request and result channels, checked against an in-bench model of the slot table.
// Depends on gha_pkg, gha_in_if, gha_out_if and the allocator RTL.
module testbench;
  import gha_pkg::*;

  localparam int PLAN  = 0;
  localparam int CHECK = 1;

  typedef struct packed {
    cmd_t                   command;
    logic [HANDLE_BITS-1:0] handle;
    logic [SLOT_BITS-1:0]   slot_index;
  } req_t;

  typedef struct packed {
    req_t       req;
    logic [3:0] gap;
    logic       hold;
    logic       calm;
  } pend_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] new_handle;
    logic                   alive;
    status_t                status;
  } reply_t;

  typedef struct packed {
    reply_t res;
    logic   calm;
  } owed_t;

  logic clk;
  logic rst_n;

  gha_in_if  in_ch ();
  gha_out_if out_ch ();

  generational_handle_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bit [HANDLE_BITS-1:0] slot_mem   [2][SLOT_DEPTH];
  bit                   slot_live  [2][SLOT_DEPTH];
  bit [SLOT_BITS:0]     slots_made [2];
  bit [HANDLE_BITS-1:0] free_top   [2];
  bit [SLOT_BITS:0]     free_len   [2];

  pend_t  req_q [$];
  owed_t  reply_q [$];
  pend_t  cur_item;
  int     req_sent;
  int     reply_got;
  int     total_n;
  int     err_cnt;
  bit     pause_next;
  bit     wear_mode;
  bit     src_calm;
  int     src_left;

  function automatic bit handle_live(input int m, input logic [HANDLE_BITS-1:0] h);
    logic [SLOT_BITS-1:0] s;
    s = h[HANDLE_BITS-1:VERSION_BITS];
    return ({1'b0, s} < slots_made[m]) && slot_live[m][s] && (slot_mem[m][s] == h);
  endfunction

  function automatic reply_t handle_step(input int m, input req_t r);
    reply_t               o;
    logic [SLOT_BITS-1:0] s;
    logic [VERSION_BITS-1:0] v;
    o.new_handle = NULL_HANDLE;
    o.alive      = 1'b0;
    o.status     = ST_OK;
    case (r.command)
      CMD_ALLOC: begin
        if (free_len[m] != 0) begin
          s = free_top[m][HANDLE_BITS-1:VERSION_BITS];
          o.new_handle    = free_top[m];
          free_top[m]     = slot_mem[m][s];
          slot_mem[m][s]  = o.new_handle;
          slot_live[m][s] = 1'b1;
          free_len[m]     = free_len[m] - 1'b1;
        end else if (slots_made[m] != SLOT_COUNT) begin
          s = slots_made[m][SLOT_BITS-1:0];
          o.new_handle    = {s, {VERSION_BITS{1'b0}}};
          slot_mem[m][s]  = o.new_handle;
          slot_live[m][s] = 1'b1;
          slots_made[m]   = slots_made[m] + 1'b1;
        end else begin
          o.status = ST_FULL;
        end
      end
      CMD_RELEASE: begin
        if (!handle_live(m, r.handle)) begin
          o.status = ST_DEAD_RELEASE;
        end else begin
          s = r.handle[HANDLE_BITS-1:VERSION_BITS];
          v = r.handle[VERSION_BITS-1:0] + 1'b1;
          slot_live[m][s] = 1'b0;
          if (v == VER_MAX) begin
            slot_mem[m][s] = {s, v};
          end else begin
            slot_mem[m][s] = free_top[m];
            free_top[m]    = {s, v};
            free_len[m]    = free_len[m] + 1'b1;
          end
        end
      end
      CMD_QUERY_HANDLE: o.alive = handle_live(m, r.handle);
      default: o.alive = ({1'b0, r.slot_index} < slots_made[m]) && slot_live[m][r.slot_index];
    endcase
    return o;
  endfunction

  function automatic logic [HANDLE_BITS-1:0] rnd_handle();
    logic [31:0] w;
    w = $urandom();
    return w[HANDLE_BITS-1:0];
  endfunction

  function automatic logic [SLOT_BITS-1:0] rnd_slot();
    logic [31:0] w;
    w = $urandom();
    return w[SLOT_BITS-1:0];
  endfunction

  function automatic logic [HANDLE_BITS-1:0] live_handle_pick();
    int n;
    int start;
    int i;
    n = int'(slots_made[PLAN]);
    if (n == 0) return NULL_HANDLE;
    start = $urandom_range(0, n - 1);
    for (i = 0; i < n; i++) begin
      if (slot_live[PLAN][(start + i) % n]) return slot_mem[PLAN][(start + i) % n];
    end
    return NULL_HANDLE;
  endfunction

  task automatic queue_req(input cmd_t c, input logic [HANDLE_BITS-1:0] h,
                           input logic [SLOT_BITS-1:0] idx, output reply_t rep);
    pend_t p;
    if (src_left == 0) begin
      src_calm = ($urandom_range(0, 3) == 0);
      src_left = $urandom_range(20, 60);
    end
    src_left--;
    p.req.command    = c;
    p.req.handle     = h;
    p.req.slot_index = idx;
    p.gap            = (src_calm || wear_mode) ? 4'd0 : 4'($urandom_range(0, 10));
    p.hold           = pause_next;
    p.calm           = wear_mode;
    pause_next       = 1'b0;
    rep              = handle_step(PLAN, p.req);
    req_q.push_back(p);
    total_n++;
  endtask

  task automatic churn_item(input int alloc_pct);
    int                      pick;
    int                      lim;
    logic [HANDLE_BITS-1:0]  h;
    logic [VERSION_BITS-1:0] vflip;
    logic [SLOT_BITS-1:0]    idx;
    reply_t                  r;
    pick  = $urandom_range(0, 99);
    h     = live_handle_pick();
    vflip = VERSION_BITS'($urandom_range(1, (1 << VERSION_BITS) - 1));
    lim   = int'(slots_made[PLAN]) + 3;
    if (lim > SLOT_DEPTH - 1) lim = SLOT_DEPTH - 1;
    idx   = $urandom_range(0, 1) ? SLOT_BITS'($urandom_range(0, lim)) : rnd_slot();
    if (pick < alloc_pct) begin
      queue_req(CMD_ALLOC, rnd_handle(), rnd_slot(), r);
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 8)
        queue_req(CMD_RELEASE, (h == NULL_HANDLE) ? rnd_handle() : h, rnd_slot(), r);
      else if (pick == 8)
        queue_req(CMD_RELEASE, h ^ {{SLOT_BITS{1'b0}}, vflip}, rnd_slot(), r);
      else if (pick == 9)
        queue_req(CMD_RELEASE, rnd_handle(), rnd_slot(), r);
      else if (pick < 13)
        queue_req(CMD_QUERY_HANDLE, h, rnd_slot(), r);
      else if (pick == 13)
        queue_req(CMD_QUERY_HANDLE, h ^ {{SLOT_BITS{1'b0}}, vflip}, rnd_slot(), r);
      else if (pick == 14)
        queue_req(CMD_QUERY_HANDLE, rnd_handle(), rnd_slot(), r);
      else
        queue_req(CMD_QUERY_SLOT, rnd_handle(), idx, r);
    end
  endtask

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_ALLOC;
    in_ch.handle        = '0;
    in_ch.slot_index    = '0;
    out_ch.ready        = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #60000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin : drv
    int     wait_cnt;
    bit     armed;
    int     sent_now;
    owed_t  o;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      armed       = 1'b0;
      wait_cnt    = 0;
      req_sent    <= 0;
    end else begin
      sent_now = req_sent;
      if (in_ch.valid && in_ch.ready) begin
        o.res  = handle_step(CHECK, cur_item.req);
        o.calm = cur_item.calm;
        reply_q.push_back(o);
        sent_now = req_sent + 1;
        req_sent <= req_sent + 1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the beat until it is taken
      end else if (req_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        if (!armed) begin
          wait_cnt = int'(req_q[0].gap);
          armed    = 1'b1;
        end
        if (wait_cnt != 0) begin
          wait_cnt--;
          in_ch.valid <= 1'b0;
        end else if (req_q[0].hold && sent_now != reply_got) begin
          in_ch.valid <= 1'b0;
        end else begin
          cur_item = req_q.pop_front();
          armed    = 1'b0;
          in_ch.valid      <= 1'b1;
          in_ch.command    <= cur_item.req.command;
          in_ch.handle     <= cur_item.req.handle;
          in_ch.slot_index <= cur_item.req.slot_index;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    int    stall_cnt;
    int    snk_left;
    bit    snk_calm;
    owed_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_cnt    = 0;
      snk_left     = 0;
      reply_got    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        reply_got <= reply_got + 1;
        if (reply_q.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected beat: new_handle %h alive %b status %0d", $time,
                   out_ch.new_handle, out_ch.alive, out_ch.status);
          stall_cnt = 0;
        end else begin
          e = reply_q.pop_front();
          if (out_ch.new_handle !== e.res.new_handle) begin
            err_cnt++;
            $display("%0t new_handle mismatch: expected %h actual %h", $time,
                     e.res.new_handle, out_ch.new_handle);
          end
          if (out_ch.alive !== e.res.alive) begin
            err_cnt++;
            $display("%0t alive mismatch: expected %b actual %b", $time,
                     e.res.alive, out_ch.alive);
          end
          if (out_ch.status !== e.res.status) begin
            err_cnt++;
            $display("%0t status mismatch: expected %0d actual %0d", $time,
                     e.res.status, out_ch.status);
          end
          if (snk_left == 0) begin
            snk_calm = ($urandom_range(0, 3) == 0);
            snk_left = $urandom_range(20, 60);
          end
          snk_left--;
          stall_cnt = (e.calm || snk_calm) ? 0 : $urandom_range(0, 10);
        end
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      out_ch.ready <= (stall_cnt == 0);
    end
  end

  initial begin : stim
    reply_t                 r;
    logic [HANDLE_BITS-1:0] h0;
    logic [HANDLE_BITS-1:0] h1;
    logic [HANDLE_BITS-1:0] h2;
    logic [HANDLE_BITS-1:0] h;
    logic [SLOT_BITS-1:0]   ws;
    int                     m;
    for (m = 0; m < 2; m++) begin
      slots_made[m] = '0;
      free_top[m]   = NULL_HANDLE;
      free_len[m]   = '0;
    end
    err_cnt    = 0;
    total_n    = 0;
    pause_next = 1'b0;
    wear_mode  = 1'b0;
    src_left   = 0;

    // empty table: nothing created yet, everything reads dead; then first allocations and queries on them
    queue_req(CMD_QUERY_SLOT, NULL_HANDLE, '0, r);
    queue_req(CMD_QUERY_HANDLE, '0, {SLOT_BITS{1'b1}}, r);
    queue_req(CMD_RELEASE, '0, '0, r);
    queue_req(CMD_RELEASE, NULL_HANDLE, {SLOT_BITS{1'b1}}, r);
    queue_req(CMD_QUERY_SLOT, '0, {SLOT_BITS{1'b1}}, r);
    queue_req(CMD_ALLOC, NULL_HANDLE, {SLOT_BITS{1'b1}}, r);
    h0 = r.new_handle;
    queue_req(CMD_ALLOC, '0, '0, r);
    h1 = r.new_handle;
    queue_req(CMD_ALLOC, rnd_handle(), rnd_slot(), r);
    h2 = r.new_handle;
    queue_req(CMD_QUERY_HANDLE, h1, '0, r);
    queue_req(CMD_QUERY_SLOT, NULL_HANDLE, SLOT_BITS'(2), r);
    queue_req(CMD_QUERY_SLOT, '0, SLOT_BITS'(3), r);
    queue_req(CMD_QUERY_HANDLE, h1 + 1'b1, '0, r);
    // release, double release, then reuse of the freed slot
    queue_req(CMD_RELEASE, h1, '0, r);
    queue_req(CMD_RELEASE, h1, '0, r);
    queue_req(CMD_QUERY_HANDLE, h1, '0, r);
    queue_req(CMD_QUERY_HANDLE, h1 + 1'b1, '0, r);
    queue_req(CMD_QUERY_SLOT, '0, SLOT_BITS'(1), r);
    queue_req(CMD_ALLOC, '0, '0, r);
    queue_req(CMD_QUERY_HANDLE, r.new_handle, '0, r);
    queue_req(CMD_RELEASE, h0, '0, r);
    queue_req(CMD_RELEASE, h2, '0, r);
    queue_req(CMD_ALLOC, '0, '0, r);
    queue_req(CMD_ALLOC, '0, '0, r);
    queue_req(CMD_ALLOC, '0, '0, r);
    queue_req(CMD_QUERY_HANDLE, NULL_HANDLE, NULL_HANDLE[SLOT_BITS-1:0], r);

    // fill the table to full, then churn around the full point
    pause_next = 1'b1;
    while (!(slots_made[PLAN] == SLOT_COUNT && free_len[PLAN] == 0)) churn_item(85);
    repeat (500) churn_item(35);

    // wear one slot down until its version is exhausted
    pause_next = 1'b1;
    wear_mode  = 1'b1;
    h  = live_handle_pick();
    ws = h[HANDLE_BITS-1:VERSION_BITS];
    queue_req(CMD_RELEASE, h, rnd_slot(), r);
    do begin
      queue_req(CMD_ALLOC, rnd_handle(), rnd_slot(), r);
      h = r.new_handle;
      queue_req(CMD_RELEASE, h, rnd_slot(), r);
    end while (h[VERSION_BITS-1:0] != VER_MAX - 1'b1);
    wear_mode = 1'b0;
    queue_req(CMD_QUERY_HANDLE, {ws, VER_MAX}, rnd_slot(), r);
    queue_req(CMD_QUERY_SLOT, rnd_handle(), ws, r);
    queue_req(CMD_RELEASE, {ws, VER_MAX}, rnd_slot(), r);
    queue_req(CMD_RELEASE, h, rnd_slot(), r);
    queue_req(CMD_ALLOC, rnd_handle(), rnd_slot(), r);
    queue_req(CMD_QUERY_SLOT, rnd_handle(), ws, r);
    repeat (40) churn_item(40);

    while (reply_got != total_n) @(posedge clk);
    repeat (16) @(posedge clk);
    if (reply_q.size() != 0) begin
      err_cnt++;
      $display("%0t %0d results never arrived", $time, reply_q.size());
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
